### design/ate_pkg.sv
// Package: shared types, command and status codes for the array table engine.
`default_nettype none
package ate_pkg;
  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 9;
  localparam int unsigned IDX_W = 8;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_SORT_UP = 3'd3;
  localparam logic [2:0] MODE_SORT_DN = 3'd4;
  localparam logic [2:0] MODE_LFIND = 3'd5;
  localparam logic [2:0] MODE_BFIND = 3'd6;
  localparam logic [2:0] MODE_READ = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [POS_W-1:0] position;
    logic signed [DATA_W-1:0] operand_value;
  } ate_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [IDX_W-1:0] found_index;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0] entry_count;
  } ate_out_t;
endpackage
`default_nettype wire

### design/array_table_engine.sv
// Top level: array table engine with its sequencer and the entry RAM.
//
//  channel | ports                        | payload
//  --------+------------------------------+-----------
//  input   | in_valid / in_ready / in_data | ate_in_t
//  result  | out_valid/out_ready/out_data  | ate_out_t
//
// One word at a time; in_ready is high only while idle and no result waits.
// Clear and rejected commands answer straight from idle; a read goes through its
// own read states; insert/delete shift one entry at a time; linear find probes
// entry by entry. Sorts run the selection sort of all n*(n-1)/2 pairs, each pair
// in turn (read a[i], read a[j], compare/write, second write), through the one RAM
// read port and one comparator.
// Binary find sorts up first, then runs a binary search over the sorted entries.
// Reset (rst_n low, synchronous) clears count and control; RAM is not
// cleared. A stalled result holds in out_data until taken.
`default_nettype none
module array_table_engine
  import ate_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire ate_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output ate_out_t     out_data
);
  // store depth is tied to the payload widths in the package
  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned AW = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHUP  = 4'd1;  // insert: read i-1
  localparam logic [3:0] S_SHUPW = 4'd2;  // insert: write i
  localparam logic [3:0] S_SHDN  = 4'd3;  // delete: read i+1
  localparam logic [3:0] S_SHDNW = 4'd4;  // delete: write i
  localparam logic [3:0] S_RDI   = 4'd5;  // sort: read a[i]
  localparam logic [3:0] S_RDJ   = 4'd6;  // sort: read a[j], latch a[i]
  localparam logic [3:0] S_CMP   = 4'd7;  // sort: compare, maybe swap
  localparam logic [3:0] S_SWP   = 4'd8;  // sort: second write of swap
  localparam logic [3:0] S_LF    = 4'd9;  // linear find probe
  localparam logic [3:0] S_LFC   = 4'd10;
  localparam logic [3:0] S_BF    = 4'd11; // binary find probe
  localparam logic [3:0] S_BFC   = 4'd12;
  localparam logic [3:0] S_RD    = 4'd13;
  localparam logic [3:0] S_RDC   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic signed [POS_W:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [DATA_W-1:0] ai_r, ai_nxt;
  ate_in_t cmd_r, cmd_nxt;
  logic out_valid_r, out_valid_nxt;
  ate_out_t out_r, out_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic signed [POS_W:0] mid;
  logic desc, swap;

  // swap: second write of old a[i] into slot j, held in spare register
  logic [DATA_W-1:0] old_r;
  logic swp_r;
  logic we_m;
  logic [AW-1:0] waddr_m;
  logic [DATA_W-1:0] wdata_m;

  ate_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we_m), .waddr(waddr_m), .wdata(wdata_m),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign mid = (lo_r + hi_r) >>> 1;
  assign desc = (cmd_r.mode == MODE_SORT_DN);
  // shared signed compare unit: a[i] vs a[j]
  assign swap = desc ? ($signed(ai_r) < $signed(rdata))
                     : ($signed(rdata) < $signed(ai_r));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    i_nxt = i_r;
    j_nxt = j_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    ai_nxt = ai_r;
    cmd_nxt = cmd_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    we = 1'b0;
    waddr = i_r[AW-1:0];
    wdata = ai_r;
    raddr = i_r[AW-1:0];
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt = in_data;
          out_nxt = '0;
          out_nxt.entry_count = count_r;
          unique case (in_data.mode) inside
            MODE_CLEAR: begin
              count_nxt = '0;
              out_nxt.entry_count = '0;
              out_valid_nxt = 1'b1;
            end
            MODE_INSERT: begin
              if (count_r >= POS_W'(DEPTH)) begin
                out_nxt.status = ST_FULL;
                out_valid_nxt = 1'b1;
              end else if (in_data.position > count_r) begin
                out_nxt.status = ST_BADPOS;
                out_valid_nxt = 1'b1;
              end else begin
                i_nxt = count_r;
                state_nxt = S_SHUP;
              end
            end
            MODE_DELETE: begin
              if (in_data.position >= count_r) begin
                out_nxt.status = ST_BADPOS;
                out_valid_nxt = 1'b1;
              end else begin
                i_nxt = in_data.position;
                state_nxt = S_SHDN;
              end
            end
            MODE_SORT_UP, MODE_SORT_DN, MODE_BFIND: begin
              i_nxt = '0;
              j_nxt = POS_W'(1);
              state_nxt = S_RDI;
            end
            MODE_LFIND: begin
              i_nxt = '0;
              state_nxt = S_LF;
            end
            default: begin
              if (in_data.position >= count_r) begin
                out_nxt.status = ST_BADPOS;
                out_valid_nxt = 1'b1;
              end else begin
                i_nxt = in_data.position;
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end
      S_SHUP: begin
        if (i_r == cmd_r.position) begin
          we = 1'b1;
          wdata = cmd_r.operand_value;
          count_nxt = count_r + POS_W'(1);
          out_nxt.entry_count = count_r + POS_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr = AW'(i_r - POS_W'(1));
          state_nxt = S_SHUPW;
        end
      end
      S_SHUPW: begin
        we = 1'b1;
        wdata = rdata;
        i_nxt = i_r - POS_W'(1);
        state_nxt = S_SHUP;
      end
      S_SHDN: begin
        if (i_r + POS_W'(1) >= count_r) begin
          count_nxt = count_r - POS_W'(1);
          out_nxt.entry_count = count_r - POS_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr = AW'(i_r + POS_W'(1));
          state_nxt = S_SHDNW;
        end
      end
      S_SHDNW: begin
        we = 1'b1;
        wdata = rdata;
        i_nxt = i_r + POS_W'(1);
        state_nxt = S_SHDN;
      end
      S_RDI: begin
        if (i_r + POS_W'(1) >= count_r) begin
          if (cmd_r.mode == MODE_BFIND) begin
            lo_nxt = '0;
            hi_nxt = {1'b0, count_r} - {{POS_W{1'b0}}, 1'b1};
            state_nxt = S_BF;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          raddr = i_r[AW-1:0];
          state_nxt = S_RDJ;
        end
      end
      S_RDJ: begin
        ai_nxt = rdata;
        raddr = j_r[AW-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (swap) begin
          // a[j] goes to slot i now, old a[i] to slot j next cycle
          we = 1'b1;
          waddr = i_r[AW-1:0];
          wdata = rdata;
          ai_nxt = rdata;
        end
        state_nxt = S_SWP;
      end
      S_SWP: begin
        state_nxt = S_RDI;
        if (j_r + POS_W'(1) >= count_r) begin
          i_nxt = i_r + POS_W'(1);
          j_nxt = i_r + POS_W'(2);
        end else begin
          j_nxt = j_r + POS_W'(1);
        end
      end
      S_LF: begin
        if (i_r >= count_r) begin
          out_nxt.status = ST_NOTFOUND;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr = i_r[AW-1:0];
          state_nxt = S_LFC;
        end
      end
      S_LFC: begin
        if (rdata == cmd_r.operand_value) begin
          out_nxt.found_index = i_r[IDX_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + POS_W'(1);
          state_nxt = S_LF;
        end
      end
      S_BF: begin
        if (lo_r > hi_r) begin
          out_nxt.status = ST_NOTFOUND;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr = mid[AW-1:0];
          state_nxt = S_BFC;
        end
      end
      S_BFC: begin
        if (rdata == cmd_r.operand_value) begin
          out_nxt.found_index = mid[IDX_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if ($signed(rdata) < $signed(cmd_r.operand_value)) begin
            lo_nxt = (POS_W+1)'(mid + 1);
          end else begin
            hi_nxt = (POS_W+1)'(mid - 1);
          end
          state_nxt = S_BF;
        end
      end
      S_RD: begin
        raddr = cmd_r.position[AW-1:0];
        state_nxt = S_RDC;
      end
      S_RDC: begin
        out_nxt.read_value = rdata;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CMP) begin
      old_r <= ai_r;
    end
    if (!rst_n) begin
      swp_r <= 1'b0;
    end else begin
      swp_r <= (state_r == S_CMP) && swap;
    end
  end

  always_comb begin
    we_m = we;
    waddr_m = waddr;
    wdata_m = wdata;
    if (state_r == S_SWP && swp_r) begin
      we_m = 1'b1;
      waddr_m = j_r[AW-1:0];
      wdata_m = old_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    ai_r <= ai_nxt;
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= POS_W'(DEPTH)) else $error("count past depth");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result dropped");
`endif
endmodule
`default_nettype wire

### design/ate_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module ate_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### tb/array_table_engine_tb.sv
// Testbench for the array table engine: random and directed commands checked against a predictor.
`timescale 1ns / 1ps
module array_table_engine_tb;
  import ate_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned RANDOM_WORDS = 1300;
  // A full-size sort runs ~32k pairs; leave a wide margin.
  localparam int unsigned STALL_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 600;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ate_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ate_out_t out_data;

  array_table_engine DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Command words waiting to go out, and results the table should produce.
  ate_in_t  cmd_queue[$];
  ate_out_t result_queue[$];

  // Shadow copy of the table.
  logic signed [DATA_W-1:0] table_mem[STORE_DEPTH];
  int unsigned              table_count;

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned mode_hits[8];
  int unsigned status_hits[4];
  int unsigned peak_count;

  function automatic ate_in_t make_cmd(logic [2:0] m, int unsigned p, logic [31:0] v);
    ate_in_t c;
    c.mode = m;
    c.position = p[POS_W-1:0];
    c.operand_value = v;
    return c;
  endfunction

  // Selection sort over all pairs, signed order.
  task automatic sort_table(bit descending);
    logic signed [DATA_W-1:0] t;
    bit swap;
    for (int i = 0; i + 1 < int'(table_count); i++) begin
      for (int j = i + 1; j < int'(table_count); j++) begin
        swap = descending ? (table_mem[i] < table_mem[j]) : (table_mem[j] < table_mem[i]);
        if (swap) begin
          t = table_mem[i];
          table_mem[i] = table_mem[j];
          table_mem[j] = t;
        end
      end
    end
  endtask

  // Work out the result of one accepted command and advance the shadow table.
  task automatic predict_table(ate_in_t c);
    ate_out_t r;
    int unsigned p;
    int lo;
    int hi;
    int mid;
    bit hit;
    p = c.position;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (c.mode)
      MODE_CLEAR: begin
        table_count = 0;
      end
      MODE_INSERT: begin
        if (table_count >= STORE_DEPTH) begin
          r.status = ST_FULL;
        end else if (p > table_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = int'(table_count); i > int'(p); i--) table_mem[i] = table_mem[i-1];
          table_mem[p] = c.operand_value;
          table_count++;
        end
      end
      MODE_DELETE: begin
        if (p >= table_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = int'(p); i + 1 < int'(table_count); i++) table_mem[i] = table_mem[i+1];
          table_count--;
        end
      end
      MODE_SORT_UP: sort_table(1'b0);
      MODE_SORT_DN: sort_table(1'b1);
      MODE_LFIND: begin
        for (int i = 0; i < int'(table_count) && !hit; i++) begin
          if (table_mem[i] == c.operand_value) begin
            hit = 1'b1;
            r.found_index = i[IDX_W-1:0];
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      MODE_BFIND: begin
        sort_table(1'b0);
        lo = 0;
        hi = int'(table_count) - 1;
        while (lo <= hi && !hit) begin
          mid = (lo + hi) / 2;
          if (table_mem[mid] == c.operand_value) begin
            hit = 1'b1;
            r.found_index = mid[IDX_W-1:0];
          end else if (table_mem[mid] < c.operand_value) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      default: begin
        if (p >= table_count) r.status = ST_BADPOS;
        else r.read_value = table_mem[p];
      end
    endcase
    r.entry_count = table_count[POS_W-1:0];
    if (table_count > peak_count) peak_count = table_count;
    mode_hits[c.mode]++;
    status_hits[r.status]++;
    result_queue.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; valid holds until taken.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 4;
      gap_left <= 0;
    end else begin
      next_valid = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        predict_table(in_data);
        words_sent++;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (cmd_queue.size() > 0) begin
          in_data <= cmd_queue.pop_front();
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            // roughly a third of bursts run back to back with no gap
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus one long hold so the input backs up.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned pattern_phase;
  bit          long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      pattern_phase <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && results_seen == 300) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      pattern_phase <= pattern_phase + 1;
      // alternate between eager windows and choppy windows
      if (pattern_phase[7:6] == 2'd0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result word with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ate_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %p", out_data);
      end else begin
        want = result_queue.pop_front();
        if (out_data.status !== want.status || out_data.found_index !== want.found_index ||
            out_data.read_value !== want.read_value ||
            out_data.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: expected st=%0d idx=%0d rd=%0d cnt=%0d, got st=%0d idx=%0d rd=%0d cnt=%0d",
                     results_seen, want.status, want.found_index, want.read_value,
                     want.entry_count, out_data.status, out_data.found_index,
                     out_data.read_value, out_data.entry_count);
        end
      end
    end
  end

  // Watchdog: too long with no word moving on either side ends the run.
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Operand values: a small pool so searches hit and duplicates appear,
  // the extremes, or fully random words.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus generation; the shadow count here only shapes positions.
  int unsigned plan_count;

  task automatic plan(logic [2:0] m, int unsigned p, logic [31:0] v);
    case (m)
      MODE_CLEAR: plan_count = 0;
      MODE_INSERT: if (plan_count < STORE_DEPTH && p <= plan_count) plan_count++;
      MODE_DELETE: if (p < plan_count) plan_count--;
      default: ;
    endcase
    cmd_queue.push_back(make_cmd(m, p, v));
  endtask

  initial begin
    int unsigned k;
    logic [2:0] m;
    int unsigned p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatches = 0;
    words_sent = 0;
    results_seen = 0;
    table_count = 0;
    peak_count = 0;
    plan_count = 0;
    for (int i = 0; i < STORE_DEPTH; i++) table_mem[i] = '0;
    foreach (mode_hits[i]) mode_hits[i] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;

    // Empty-store corner cases.
    plan(MODE_CLEAR, 0, 0);
    plan(MODE_READ, 0, 0);
    plan(MODE_DELETE, 0, 0);
    plan(MODE_LFIND, 0, 5);
    plan(MODE_BFIND, 0, 5);
    plan(MODE_SORT_UP, 0, 0);
    plan(MODE_SORT_DN, 0, 0);
    plan(MODE_INSERT, 1, 3);
    // Small table with extremes and duplicates.
    plan(MODE_INSERT, 0, 32'h7FFF_FFFF);
    plan(MODE_INSERT, 0, 32'h8000_0000);
    plan(MODE_INSERT, 2, 0);
    plan(MODE_INSERT, 1, 32'hFFFF_FFFF);
    plan(MODE_INSERT, 4, 0);
    plan(MODE_INSERT, 6, 9);
    plan(MODE_READ, 4, 0);
    plan(MODE_READ, 5, 0);
    plan(MODE_READ, 511, 0);
    plan(MODE_SORT_DN, 0, 0);
    plan(MODE_LFIND, 0, 0);
    plan(MODE_BFIND, 0, 0);
    plan(MODE_BFIND, 0, 7);
    plan(MODE_DELETE, 4, 0);
    plan(MODE_DELETE, 0, 0);
    plan(MODE_SORT_UP, 0, 0);
    plan(MODE_READ, 0, 0);

    // Bulk load to full, then the full-store cases and one full-size sort.
    plan(MODE_CLEAR, 0, 0);
    for (int i = 0; i < STORE_DEPTH; i++) plan(MODE_INSERT, i, $urandom);
    plan(MODE_INSERT, 0, 1);
    plan(MODE_INSERT, 300, 1);
    plan(MODE_READ, 255, 0);
    plan(MODE_LFIND, 0, 32'h8000_0000);
    plan(MODE_SORT_DN, 0, 0);
    plan(MODE_READ, 0, 0);
    plan(MODE_DELETE, 255, 0);
    plan(MODE_INSERT, 255, 32'h1234_5678);
    plan(MODE_CLEAR, 0, 0);

    // Random part: mostly clear + bulk load + mixed commands on a small table.
    k = 0;
    while (k < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) != 0) begin
        plan(MODE_CLEAR, 0, 0);
        k++;
        repeat ($urandom_range(0, 12)) begin
          plan(MODE_INSERT, plan_count, pick_value());
          k++;
        end
      end
      repeat ($urandom_range(5, 20)) begin
        m = 3'($urandom_range(1, 7));
        if ($urandom_range(0, 30) == 0) m = MODE_CLEAR;
        // keep sorts and shifts cheap
        if (m == MODE_INSERT && plan_count >= 40) m = MODE_DELETE;
        if ($urandom_range(0, 7) == 0) p = $urandom_range(0, 511);
        else p = $urandom_range(0, plan_count + 1);
        plan(m, p, pick_value());
        k++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() > 0 || in_valid) @(posedge clk);
    while (result_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (result_queue.size() > 0) mismatches += result_queue.size();
    $display("Sent %0d commands (clr %0d ins %0d del %0d sort %0d/%0d lfind %0d bfind %0d rd %0d)",
             words_sent, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
             mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
    $display("Results %0d: ok %0d full %0d badpos %0d notfound %0d, peak count %0d",
             results_seen, status_hits[0], status_hits[1], status_hits[2],
             status_hits[3], peak_count);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
design/ate_pkg.sv
design/ate_ram.sv
design/array_table_engine.sv
tb/array_table_engine_tb.sv
